// ===== rtl/core/mld_pkg.sv =====
// ----------------------------------------------------------------------------
// mld_pkg: shared types and constants
// Widths, register codes and stage payload types of the masked Laplacian
// diffusion rate block.
// ----------------------------------------------------------------------------
package mld_pkg;

  // Line buffer geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int IW_W      = 11;
  localparam int EW_W      = (COL_W + 1 > IW_W) ? COL_W + 1 : IW_W;
  localparam int ROWS_W    = 2;

  // Field widths
  localparam int COLOUR_W   = 32;
  localparam int VAL_W      = 32;
  localparam int GAIN_W     = 32;
  localparam int RATE_W     = 48;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int SUM_W  = VAL_W + 3;
  localparam int MAG_W  = VAL_W + 2;
  localparam int PROD_W = MAG_W + FRAC_W;
  localparam int RES_W  = PROD_W + 1;
  localparam int LOR_W  = RES_W - FRAC_W;

  // Reset values and limits
  localparam logic [IW_W-1:0]   WIDTH_RESET = IW_W'(1024);
  localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(32'h0001_0000);
  localparam logic [RES_W-1:0]  ROUND_HALF  = RES_W'(1) << (FRAC_W - 1);
  localparam logic [RATE_W-1:0] SAT_POS     = {1'b0, {(RATE_W - 1){1'b1}}};
  localparam logic [RATE_W-1:0] SAT_NEG     = {1'b1, {(RATE_W - 1){1'b0}}};
  localparam logic [ROWS_W-1:0] ROWS_FULL   = ROWS_W'(2);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH        = 2'd0,
    REG_COMPARTMENT_COLOUR = 2'd1,
    REG_DIFFUSION_GAIN     = 2'd2
  } mld_reg_t;

  // Active configuration
  typedef struct packed {
    logic [EW_W-1:0]     eff_width;
    logic [COLOUR_W-1:0] colour;
    logic [GAIN_W-1:0]   gain;
  } mld_cfg_t;

  // Line buffer entry: value and compartment mark
  typedef struct packed {
    logic             mark;
    logic [VAL_W-1:0] val;
  } mld_cell_t;

  // Flags that travel with a result
  typedef struct packed {
    logic in_comp;
    logic last;
  } mld_tag_t;

  // Stencil window after boundary substitution
  typedef struct packed {
    mld_tag_t         tag;
    logic [VAL_W-1:0] ctr;
    logic [VAL_W-1:0] up;
    logic [VAL_W-1:0] dn;
    logic [VAL_W-1:0] lf;
    logic [VAL_W-1:0] rt;
  } mld_win_t;

endpackage

// ===== rtl/core/mld_in_if.sv =====
// ----------------------------------------------------------------------------
// mld_in_if: pixel request channel
// Valid/ready channel carrying one geometry pixel and its concentration.
// ----------------------------------------------------------------------------
interface mld_in_if;
  import mld_pkg::*;

  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] pixel_colour;
  logic [VAL_W-1:0]    concentration;
  logic                frame_end;

  modport source (output valid, output pixel_colour, output concentration,
                  output frame_end, input ready);
  modport sink   (input valid, input pixel_colour, input concentration,
                  input frame_end, output ready);
endinterface

// ===== rtl/core/mld_out_if.sv =====
// ----------------------------------------------------------------------------
// mld_out_if: rate request channel
// Valid/ready channel carrying one diffusion rate result.
// ----------------------------------------------------------------------------
interface mld_out_if;
  import mld_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] rate_of_change;
  logic                     inside_compartment;
  logic                     last_of_frame;

  modport source (output valid, output rate_of_change, output inside_compartment,
                  output last_of_frame, input ready);
  modport sink   (input valid, input rate_of_change, input inside_compartment,
                  input last_of_frame, output ready);
endinterface

// ===== rtl/core/mld_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mld_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mld_cfg_if;
  import mld_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mld_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mld_cfg_regs: configuration registers
// Holds image width, compartment colour and gain; derives the usable width.
// ----------------------------------------------------------------------------
module mld_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  mld_cfg_if.sink           cfg_ch,
  output mld_pkg::mld_cfg_t cfg
);
  import mld_pkg::*;

  logic [IW_W-1:0]     width_r;
  logic [COLOUR_W-1:0] colour_r;
  logic [GAIN_W-1:0]   gain_r;

  // Writes are always taken
  assign cfg_ch.ready = 1'b1;

  // Decode and store register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      colour_r <= '0;
      gain_r   <= GAIN_RESET;
    end else if (cfg_ch.valid) begin
      unique case (mld_reg_t'(cfg_ch.index))
        REG_IMAGE_WIDTH:        width_r  <= cfg_ch.data[IW_W-1:0];
        REG_COMPARTMENT_COLOUR: colour_r <= cfg_ch.data[COLOUR_W-1:0];
        REG_DIFFUSION_GAIN:     gain_r   <= cfg_ch.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one column, anything past the line buffer as full depth
  always_comb begin
    cfg.colour = colour_r;
    cfg.gain   = gain_r;
    if (width_r == '0) begin
      cfg.eff_width = EW_W'(1);
    end else if (EW_W'(width_r) > EW_W'(MAX_WIDTH)) begin
      cfg.eff_width = EW_W'(MAX_WIDTH);
    end else begin
      cfg.eff_width = EW_W'(width_r);
    end
  end

endmodule

// ===== rtl/core/mld_line_buf.sv =====
// ----------------------------------------------------------------------------
// mld_line_buf: two-row line buffer and stencil window
// Tracks the raster position, keeps the two previous rows and builds the
// five-point window with zero-flux substitution for each accepted pixel.
// ----------------------------------------------------------------------------
module mld_line_buf (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mld_pkg::mld_cfg_t               cfg,
  input  logic                            fire,
  input  logic [mld_pkg::COLOUR_W-1:0]    pixel_colour,
  input  logic [mld_pkg::VAL_W-1:0]       concentration,
  input  logic                            frame_end,
  output logic                            win_valid,
  output mld_pkg::mld_win_t               win
);
  import mld_pkg::*;

  mld_cell_t         mid_mem [MAX_WIDTH];
  mld_cell_t         up_mem  [MAX_WIDTH];

  mld_cell_t         mid_c_r;
  mld_cell_t         mid_n_r;
  mld_cell_t         up_c_r;
  mld_cell_t         left_r;
  mld_cell_t         new_cell;

  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic [COL_W-1:0]  rd_col;
  logic [COL_W-1:0]  rd_col_n;
  logic [ROWS_W-1:0] rows_r;
  logic [ROWS_W-1:0] rows_nxt;
  logic [EW_W-1:0]   col_plus;
  logic              last_col;

  // Advance the raster position
  always_comb begin
    new_cell.mark = (pixel_colour == cfg.colour);
    new_cell.val  = concentration;
    col_plus      = EW_W'(col_r) + EW_W'(1);
    last_col      = (col_plus >= cfg.eff_width);
    col_nxt       = col_r;
    rows_nxt      = rows_r;
    if (fire) begin
      if (frame_end) begin
        col_nxt  = '0;
        rows_nxt = '0;
      end else if (last_col) begin
        col_nxt  = '0;
        rows_nxt = (rows_r == ROWS_FULL) ? rows_r : rows_r + ROWS_W'(1);
      end else begin
        col_nxt  = col_r + COL_W'(1);
      end
    end
    rd_col   = col_nxt;
    rd_col_n = col_nxt + COL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rows_r <= '0;
    end else begin
      col_r  <= col_nxt;
      rows_r <= rows_nxt;
    end
  end

  // Shift the column down one row and prefetch the next window,
  // forwarding the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (fire) begin
      mid_mem[col_r] <= new_cell;
      up_mem[col_r]  <= mid_c_r;
      left_r         <= mid_c_r;
    end
    mid_c_r <= (fire && col_r == rd_col)   ? new_cell : mid_mem[rd_col];
    mid_n_r <= (fire && col_r == rd_col_n) ? new_cell : mid_mem[rd_col_n];
    up_c_r  <= (fire && col_r == rd_col)   ? mid_c_r  : up_mem[rd_col];
  end

  // Build the window; neighbours outside count as the centre
  always_comb begin
    win_valid       = fire && (rows_r != '0);
    win.tag.in_comp = mid_c_r.mark;
    win.tag.last    = frame_end;
    win.ctr         = '0;
    win.up          = '0;
    win.dn          = '0;
    win.lf          = '0;
    win.rt          = '0;
    if (mid_c_r.mark) begin
      win.ctr = mid_c_r.val;
      win.up  = (rows_r == ROWS_FULL && up_c_r.mark) ? up_c_r.val : mid_c_r.val;
      win.dn  = new_cell.mark ? new_cell.val : mid_c_r.val;
      win.lf  = (col_r != '0 && left_r.mark) ? left_r.val : mid_c_r.val;
      win.rt  = (!last_col && mid_n_r.mark) ? mid_n_r.val : mid_c_r.val;
    end
  end

  // Row counter saturates at two
  a_rows_range: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= ROWS_FULL)
    else $error("row count out of range");

  // Frame end restarts the raster
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && frame_end |=> col_r == '0 && rows_r == '0)
    else $error("frame end did not restart position");

  // Inside a row the column steps by one
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !frame_end && !last_col |=> col_r == $past(col_r) + COL_W'(1))
    else $error("column did not advance");

endmodule

// ===== rtl/core/mld_rate_pipe.sv =====
// ----------------------------------------------------------------------------
// mld_rate_pipe: stencil arithmetic pipeline
// Sums the window, scales by the gain with round-half-away rounding and
// saturates to 48 bits. Every stage has its own valid and stalls alone.
// ----------------------------------------------------------------------------
module mld_rate_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mld_pkg::GAIN_W-1:0] gain,
  input  logic                       win_valid,
  input  mld_pkg::mld_win_t          win,
  output logic                       win_ready,
  mld_out_if.source                  out_ch
);
  import mld_pkg::*;

  // Stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdyo;

  // Stage payloads
  mld_win_t              w1_r;
  logic [SUM_W-1:0]      sum2_r, sum2_nxt;
  mld_tag_t              t2_r, t3_r, t4_r, t5_r, t6_r, to_r;
  logic [MAG_W-1:0]      mag3_r, mag3_nxt;
  logic                  neg3_r, neg4_r, neg5_r, neg6_r;
  logic [PROD_W-1:0]     phi4_r, phi4_nxt, plo4_r, plo4_nxt;
  logic [PROD_W-1:0]     phi5_r;
  logic [LOR_W-1:0]      lor5_r, lor5_nxt;
  logic [RES_W-1:0]      rnd_sum;
  logic [RES_W-1:0]      res;
  logic [RATE_W-1:0]     lim;
  logic [RATE_W-1:0]     mag6_r, mag6_nxt;
  logic [RATE_W-1:0]     rate_r, rate_nxt;
  logic [SUM_W-1:0]      neg_sum;

  // A stage takes new data when empty or when it drains
  always_comb begin
    rdyo      = !vo_r || out_ch.ready;
    rdy6      = !v6_r || rdyo;
    rdy5      = !v5_r || rdy6;
    rdy4      = !v4_r || rdy5;
    rdy3      = !v3_r || rdy4;
    rdy2      = !v2_r || rdy3;
    rdy1      = !v1_r || rdy2;
    win_ready = rdy1;
  end

  // Datapath of each stage
  always_comb begin
    sum2_nxt = SUM_W'(w1_r.up) + SUM_W'(w1_r.dn) + SUM_W'(w1_r.lf) + SUM_W'(w1_r.rt)
             - {1'b0, w1_r.ctr, 2'b00};
    neg_sum  = '0 - sum2_r;
    mag3_nxt = sum2_r[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum2_r[MAG_W-1:0];
    phi4_nxt = {{FRAC_W{1'b0}}, mag3_r} * {{MAG_W{1'b0}}, gain[GAIN_W-1:FRAC_W]};
    plo4_nxt = {{FRAC_W{1'b0}}, mag3_r} * {{MAG_W{1'b0}}, gain[FRAC_W-1:0]};
    rnd_sum  = {1'b0, plo4_r} + ROUND_HALF;
    lor5_nxt = rnd_sum[RES_W-1:FRAC_W];
    res      = {1'b0, phi5_r} + RES_W'(lor5_r);
    lim      = neg5_r ? SAT_NEG : SAT_POS;
    mag6_nxt = (res > RES_W'(lim)) ? lim : res[RATE_W-1:0];
    rate_nxt = neg6_r ? ('0 - mag6_r) : mag6_r;
  end

  // Hold valids under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= win_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdyo) vo_r <= v6_r;
    end
  end

  // Advance payloads
  always_ff @(posedge clk) begin
    if (rdy1) begin
      w1_r <= win;
    end
    if (rdy2) begin
      sum2_r <= sum2_nxt;
      t2_r   <= w1_r.tag;
    end
    if (rdy3) begin
      mag3_r <= mag3_nxt;
      neg3_r <= sum2_r[SUM_W-1];
      t3_r   <= t2_r;
    end
    if (rdy4) begin
      phi4_r <= phi4_nxt;
      plo4_r <= plo4_nxt;
      neg4_r <= neg3_r;
      t4_r   <= t3_r;
    end
    if (rdy5) begin
      phi5_r <= phi4_r;
      lor5_r <= lor5_nxt;
      neg5_r <= neg4_r;
      t5_r   <= t4_r;
    end
    if (rdy6) begin
      mag6_r <= mag6_nxt;
      neg6_r <= neg5_r;
      t6_r   <= t5_r;
    end
    if (rdyo) begin
      rate_r <= rate_nxt;
      to_r   <= t6_r;
    end
  end

  // Drive the result request
  always_comb begin
    out_ch.valid              = vo_r;
    out_ch.rate_of_change     = $signed(rate_r);
    out_ch.inside_compartment = to_r.in_comp;
    out_ch.last_of_frame      = to_r.last;
  end

  // A pixel outside the compartment reports zero
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.inside_compartment |-> out_ch.rate_of_change == '0)
    else $error("outside pixel gave nonzero rate");

endmodule

// ===== rtl/core/masked_laplacian_diffusion_rate.sv =====
// ----------------------------------------------------------------------------
// masked_laplacian_diffusion_rate: masked five-point diffusion rate
// Takes a raster pixel stream and returns the zero-flux Laplacian rate of the
// pixel one row above each incoming pixel.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock while the first pipeline stage is free and
// returns one rate request per pixel from the second row of a frame on, built
// when the pixel below it is taken; the first row of a frame and a frame end
// inside it give no result. The line buffers take one write per accepted
// pixel and prefetch the next window each clock, and results pass through an
// arithmetic pipeline whose stages stall one by one, so a waiting result does
// not stop intake until the whole pipeline is full. Line buffers hold
// MAX_WIDTH columns and need no clearing after reset. Append one padding row
// outside the compartment and flag its last pixel as frame end.
module masked_laplacian_diffusion_rate (
  input  logic       clk,
  input  logic       rst_n,
  mld_in_if.sink     in_ch,
  mld_out_if.source  out_ch,
  mld_cfg_if.sink    cfg_ch
);
  import mld_pkg::*;

  mld_cfg_t cfg;
  mld_win_t win;
  logic     win_valid;
  logic     win_ready;
  logic     fire;

  // Take a pixel when the first pipeline stage is free
  assign in_ch.ready = win_ready;
  assign fire        = in_ch.valid && win_ready;

  mld_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  mld_line_buf u_line_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .fire          (fire),
    .pixel_colour  (in_ch.pixel_colour),
    .concentration (in_ch.concentration),
    .frame_end     (in_ch.frame_end),
    .win_valid     (win_valid),
    .win           (win)
  );

  mld_rate_pipe u_rate_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (cfg.gain),
    .win_valid (win_valid),
    .win       (win),
    .win_ready (win_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for masked_laplacian_diffusion_rate
// Streams raster frames with a trailing padding row into the block, tracks
// the line buffers and the zero-flux stencil alongside it, and compares every
// rate request in order. Random gaps on both channels; configuration changes
// happen only between closed frames.
// ----------------------------------------------------------------------------
module tb;
  import mld_pkg::*;

  localparam int RANDOM_PIXELS = 600;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 4000;

  // One rate request as the block should return it
  typedef struct {
    logic [RATE_W-1:0] rate;
    logic              in_comp;
    logic              last;
  } rate_req_t;

  logic clk = 1'b0;
  logic rst_n;

  mld_in_if  in_if ();
  mld_out_if out_if ();
  mld_cfg_if cfg_if ();

  masked_laplacian_diffusion_rate dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the configuration registers
  logic [IW_W-1:0]     width_reg;
  logic [COLOUR_W-1:0] colour_reg;
  logic [GAIN_W-1:0]   gain_reg;

  // Shadow line buffers: row r-2 and row r-1
  logic [VAL_W-1:0] above_conc [MAX_WIDTH];
  logic             above_in   [MAX_WIDTH];
  logic [VAL_W-1:0] row_conc   [MAX_WIDTH];
  logic             row_in     [MAX_WIDTH];
  int unsigned      col_pos;
  int unsigned      rows_seen;

  rate_req_t expected_rates[$];
  int        failures;
  int        sent_pixels;
  bit        tx_calm;
  bit        rx_calm;

  // Scale a stencil sum by the Q16.16 gain, round half away, saturate to 48 bits
  function automatic logic [RATE_W-1:0] scaled_rate(input longint sum);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] res;
    logic [63:0] flipped;
    neg = sum < 0;
    mag = neg ? 64'(-sum) : 64'(sum);
    res = mag * gain_reg[31:16] + ((mag * gain_reg[15:0] + 64'h8000) >> 16);
    if (neg) begin
      if (res > 64'h0000_8000_0000_0000) res = 64'h0000_8000_0000_0000;
      flipped = 64'd0 - res;
      return flipped[RATE_W-1:0];
    end
    if (res > 64'h0000_7FFF_FFFF_FFFF) res = 64'h0000_7FFF_FFFF_FFFF;
    return res[RATE_W-1:0];
  endfunction

  // Append one rate request to the expectation queue
  task automatic append_expected(input rate_req_t req);
    expected_rates.insert(expected_rates.size(), req);
  endtask

  // Advance the shadow state by one accepted pixel and queue its rate request
  task automatic track_pixel(input logic [COLOUR_W-1:0] colour,
                             input logic [VAL_W-1:0] conc, input logic fend);
    int unsigned w;
    int unsigned c;
    logic        mark;
    longint      ctr, up, dn, lf, rt;
    rate_req_t   req;
    w = (width_reg == '0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
    c = col_pos;
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    mark = (colour == colour_reg);
    if (rows_seen >= 1) begin
      req.rate    = '0;
      req.in_comp = row_in[c];
      req.last    = fend;
      if (row_in[c]) begin
        ctr = longint'(row_conc[c]);
        up  = ctr;
        dn  = ctr;
        lf  = ctr;
        rt  = ctr;
        if (rows_seen >= 2 && above_in[c]) up = longint'(above_conc[c]);
        if (mark) dn = longint'(conc);
        if (c > 0 && above_in[c-1]) lf = longint'(above_conc[c-1]);
        if (c + 1 < w && c + 1 < MAX_WIDTH && row_in[c+1]) rt = longint'(row_conc[c+1]);
        req.rate = scaled_rate(up + dn + lf + rt - 4 * ctr);
      end
      append_expected(req);
    end
    above_conc[c] = row_conc[c];
    above_in[c]   = row_in[c];
    row_conc[c]   = conc;
    row_in[c]     = mark;
    if (fend) begin
      col_pos   = 0;
      rows_seen = 0;
    end else if (c + 1 >= w) begin
      col_pos = 0;
      if (rows_seen < 2) rows_seen++;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Send one pixel request; valid stays high when the next one follows at once
  task automatic send_pixel(input logic [COLOUR_W-1:0] colour,
                            input logic [VAL_W-1:0] conc, input logic fend);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.pixel_colour  <= colour;
    in_if.concentration <= conc;
    in_if.frame_end     <= fend;
    do @(posedge clk); while (!in_if.ready);
    track_pixel(colour, conc, fend);
    sent_pixels++;
  endtask

  task automatic write_reg(input mld_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_IMAGE_WIDTH:        width_reg  = value[IW_W-1:0];
      REG_COMPARTMENT_COLOUR: colour_reg = value;
      REG_DIFFUSION_GAIN:     gain_reg   = value;
      default: ;
    endcase
  endtask

  // Write all three registers back to back
  task automatic configure(input logic [31:0] width_data, input logic [31:0] colour,
                           input logic [31:0] gain);
    write_reg(REG_IMAGE_WIDTH, width_data);
    write_reg(REG_COMPARTMENT_COLOUR, colour);
    write_reg(REG_DIFFUSION_GAIN, gain);
    cfg_if.valid <= 1'b0;
  endtask

  // Drop valid, drain all outstanding rates, then let the pipeline empty
  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COLOUR_W-1:0] outside_colour();
    return colour_reg ^ ($urandom() | (32'h1 << $urandom_range(0, 31)));
  endfunction

  function automatic logic [VAL_W-1:0] random_conc();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return VAL_W'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  // Send rows of real pixels plus the padding row; a cut ends the frame early
  task automatic send_frame(input int cols, input int rows, input int cut,
                            input int inside_pct);
    int   total;
    int   stop;
    logic in_comp;
    total = cols * (rows + 1);
    stop  = (cut >= 0) ? cut : total - 1;
    for (int i = 0; i <= stop; i++) begin
      in_comp = (i < cols * rows) && ($urandom_range(0, 99) < inside_pct);
      send_pixel(in_comp ? colour_reg : outside_colour(), random_conc(), i == stop);
    end
  endtask

  // Frame end inside the first row at reset settings: no rate requests
  task automatic test_first_row_frame_end();
    send_pixel(colour_reg, 32'h0001_0000, 1'b0);
    send_pixel(outside_colour(), 32'hFFFF_FFFF, 1'b0);
    send_pixel(colour_reg, 32'h0000_0000, 1'b1);
  endtask

  // Full-scale concentrations at maximum gain drive both saturation limits
  task automatic test_saturation();
    quiesce();
    configure(32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 32'h1234_5678, 1'b0);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
  endtask

  // Zero width acts as one column; half gain exercises ties away from zero
  task automatic test_rounding_single_column();
    quiesce();
    configure(32'd0, 32'hA5A5_0F0F, 32'h0000_8000);
    send_pixel(32'hA5A5_0F0F, 32'd0, 1'b0);
    send_pixel(32'hA5A5_0F0F, 32'd1, 1'b0);
    send_pixel(32'hA5A5_0F0F, 32'd4, 1'b0);
    send_pixel(32'h5A5A_F0F0, 32'd0, 1'b1);
  endtask

  // Mostly well-formed frames of small widths, some cut short
  task automatic test_random_frames();
    int start;
    int width_val;
    int cols;
    int rows;
    int cut;
    logic [31:0] gain;
    start = sent_pixels;
    while (sent_pixels - start < RANDOM_PIXELS) begin
      quiesce();
      case ($urandom_range(0, 9))
        0:       width_val = 0;
        1:       width_val = 1;
        2:       width_val = 2;
        3:       width_val = $urandom_range(13, 40);
        default: width_val = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 7))
        0:       gain = 32'h0000_0000;
        1:       gain = 32'hFFFF_FFFF;
        2:       gain = 32'h0001_0000;
        3:       gain = 32'h0000_8000;
        4:       gain = $urandom_range(0, 32'h3_FFFF);
        default: gain = $urandom();
      endcase
      configure(($urandom() & ~32'h7FF) | width_val, $urandom(), gain);
      cols = (width_val == 0) ? 1 : width_val;
      repeat ($urandom_range(1, 3)) begin
        rows = $urandom_range(1, 4);
        cut  = ($urandom_range(0, 99) < 15) ? $urandom_range(0, cols * rows - 1) : -1;
        tx_calm = ($urandom_range(0, 3) == 0);
        send_frame(cols, rows, cut, $urandom_range(40, 95));
      end
    end
  endtask

  // Result side: hold ready low for a random stall before each request
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    rx_calm = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Compare each accepted rate request with the oldest expectation
  always @(posedge clk) begin : check_rates
    rate_req_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_rates.size() == 0) begin
        $display("%0t: unexpected rate request, expected none, got rate %h inside %b last %b",
                 $time, out_if.rate_of_change, out_if.inside_compartment,
                 out_if.last_of_frame);
        failures++;
      end else begin
        want = expected_rates.pop_front();
        if (out_if.rate_of_change !== want.rate) begin
          $display("%0t: rate_of_change expected %h got %h",
                   $time, want.rate, out_if.rate_of_change);
          failures++;
        end
        if (out_if.inside_compartment !== want.in_comp) begin
          $display("%0t: inside_compartment expected %b got %b",
                   $time, want.in_comp, out_if.inside_compartment);
          failures++;
        end
        if (out_if.last_of_frame !== want.last) begin
          $display("%0t: last_of_frame expected %b got %b",
                   $time, want.last, out_if.last_of_frame);
          failures++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int waited;
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.pixel_colour  <= '0;
    in_if.concentration <= '0;
    in_if.frame_end     <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_IMAGE_WIDTH;
    cfg_if.data         <= '0;
    width_reg   = WIDTH_RESET;
    colour_reg  = '0;
    gain_reg    = GAIN_RESET;
    col_pos     = 0;
    rows_seen   = 0;
    failures    = 0;
    sent_pixels = 0;
    tx_calm     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_first_row_frame_end();
    test_saturation();
    test_rounding_single_column();
    test_random_frames();

    // Drain what is still in flight, bounded
    in_if.valid <= 1'b0;
    waited = 0;
    while (expected_rates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_rates.size() != 0) begin
      $display("%0t: %0d rate requests never arrived", $time, expected_rates.size());
      failures++;
    end
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
